FILE: rtl/pms_pkg.sv
package pms_pkg;

	localparam int SLOT_W    = 6;
	localparam int SRC_W     = 8;
	localparam int KIND_W    = 8;
	localparam int PERIOD_W  = 24;
	localparam int SEQ_W     = 16;
	localparam int VER_W     = 16;
	localparam int TS_W      = 32;
	localparam int MAX_EMIT  = 64;
	localparam int EMIT_W    = 7;
	localparam int MOD_CNT_W = 5;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SEARCH,
		ST_FLUSH
	} pms_state_t;

	typedef struct packed {
		logic clear_emitted;
		logic emit_sel;
		logic load_sel;
		logic disable_sel;
	} pms_cell_ctrl_t;

	typedef struct packed {
		logic [SRC_W-1:0]    source;
		logic [KIND_W-1:0]   kind;
		logic [PERIOD_W-1:0] period;
	} pms_load_t;

	typedef struct packed {
		logic [SRC_W-1:0]  source;
		logic [KIND_W-1:0] kind;
		logic [SEQ_W-1:0]  seq;
	} pms_pay_t;

endpackage

FILE: rtl/pms_mod.sv
module pms_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [pms_pkg::PERIOD_W-1:0]  num,
	input  logic [pms_pkg::PERIOD_W-1:0]  den,
	output logic                          done,
	output logic [pms_pkg::PERIOD_W-1:0]  rem
);
	import pms_pkg::*;

	logic                 run_q;
	logic                 done_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [PERIOD_W-1:0]  num_q;
	logic [PERIOD_W-1:0]  den_q;
	logic [PERIOD_W-1:0]  rem_q;
	logic [PERIOD_W:0]    trial;
	logic [PERIOD_W:0]    rem_next;

	// One restoring step per cycle: bring down the next dividend bit and
	// subtract the divisor when it fits. The remainder stays below a nonzero den.
	always_comb begin
		trial = {rem_q, num_q[PERIOD_W-1]};
		if (trial >= {1'b0, den_q}) begin
			rem_next = trial - {1'b0, den_q};
		end else begin
			rem_next = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + MOD_CNT_W'(1);
				if (cnt_q == MOD_CNT_W'(PERIOD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[PERIOD_W-2:0], 1'b0};
			rem_q <= rem_next[PERIOD_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/pms_cell.sv
module pms_cell #(
	parameter int TIME_BITS = 32,
	parameter int IDX_W     = 6,
	parameter int CELL_IDX  = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [TIME_BITS-1:0]    now,
	input  pms_pkg::pms_cell_ctrl_t ctrl,
	input  pms_pkg::pms_load_t      load,
	input  logic [TIME_BITS-1:0]    load_due,
	input  logic                    in_valid,
	input  logic [TIME_BITS-1:0]    in_late,
	input  logic [IDX_W-1:0]        in_idx,
	input  pms_pkg::pms_pay_t       in_pay,
	output logic                    out_valid,
	output logic [TIME_BITS-1:0]    out_late,
	output logic [IDX_W-1:0]        out_idx,
	output pms_pkg::pms_pay_t       out_pay
);
	import pms_pkg::*;

	localparam int SUM_W = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;

	logic                 valid_q;
	logic                 emitted_q;
	logic [SRC_W-1:0]     source_q;
	logic [KIND_W-1:0]    kind_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [TIME_BITS-1:0] due_q;
	logic [SEQ_W-1:0]     seq_q;

	logic                 out_valid_q;
	logic [TIME_BITS-1:0] out_late_q;
	logic [IDX_W-1:0]     out_idx_q;
	pms_pay_t             out_pay_q;

	logic [TIME_BITS-1:0] late;
	logic                 cand;
	logic                 take;
	logic [SUM_W-1:0]     next_due;
	pms_pay_t             own_pay;

	// A slot is due while its lateness has the top bit clear. The incoming
	// candidate comes from lower slots, so on equal lateness it is kept.
	always_comb begin
		late           = now - due_q;
		cand           = valid_q && !emitted_q && !late[TIME_BITS-1];
		take           = cand && (!in_valid || (late > in_late));
		next_due       = SUM_W'(due_q) + SUM_W'(period_q);
		own_pay.source = source_q;
		own_pay.kind   = kind_q;
		own_pay.seq    = seq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			emitted_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.load_sel) begin
				valid_q <= 1'b1;
			end else if (ctrl.disable_sel) begin
				valid_q <= 1'b0;
			end
			if (ctrl.clear_emitted) begin
				emitted_q <= 1'b0;
			end else if (ctrl.emit_sel) begin
				emitted_q <= 1'b1;
			end
			out_valid_q <= in_valid || cand;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_sel) begin
			source_q <= load.source;
			kind_q   <= load.kind;
			period_q <= load.period;
			due_q    <= load_due;
			seq_q    <= '0;
		end else if (ctrl.emit_sel) begin
			due_q <= next_due[TIME_BITS-1:0];
			seq_q <= seq_q + SEQ_W'(1);
		end
		out_late_q <= take ? late : in_late;
		out_idx_q  <= take ? IDX_W'(CELL_IDX) : in_idx;
		out_pay_q  <= take ? own_pay : in_pay;
	end

	assign out_valid = out_valid_q;
	assign out_late  = out_late_q;
	assign out_idx   = out_idx_q;
	assign out_pay   = out_pay_q;

endmodule

FILE: rtl/periodic_message_scheduler_core.sv
// Channel   Handshake                          Fields
// command   start in, busy out                 cmd slot source_node message_kind
//                                              period start_offset
// result    strobe out, one cycle, no stall    out_slot out_source out_kind
//                                              out_sequence out_version
//                                              out_timestamp last
// config    APB psel penable pwrite pready     paddr pwdata prdata (header_version)
//
// A nonzero-period load keeps busy high while the start offset is reduced
// modulo the period one bit per cycle. Other loads never raise busy.
// A tick runs one search per emission while the best candidate walks the row
// of slot cells, then a final empty search, or a flush state once MAX_EMIT
// emissions are out. Reset clears the clock, slot enables and header version.
// Results cannot be stalled; a full tick's last follows the one before at once.
module periodic_message_scheduler_core #(
	parameter int NUM_SLOTS = 64,
	parameter int TIME_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         cmd,
	input  logic [pms_pkg::SLOT_W-1:0]   slot,
	input  logic [pms_pkg::SRC_W-1:0]    source_node,
	input  logic [pms_pkg::KIND_W-1:0]   message_kind,
	input  logic [pms_pkg::PERIOD_W-1:0] period,
	input  logic [pms_pkg::PERIOD_W-1:0] start_offset,
	output logic                         strobe,
	output logic [pms_pkg::SLOT_W-1:0]   out_slot,
	output logic [pms_pkg::SRC_W-1:0]    out_source,
	output logic [pms_pkg::KIND_W-1:0]   out_kind,
	output logic [pms_pkg::SEQ_W-1:0]    out_sequence,
	output logic [pms_pkg::VER_W-1:0]    out_version,
	output logic [pms_pkg::TS_W-1:0]     out_timestamp,
	output logic                         last,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [1:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import pms_pkg::*;

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);
	localparam int SUM_W = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;

	pms_state_t           state_q;
	pms_state_t           state_d;
	logic [TIME_BITS-1:0] now_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [EMIT_W-1:0]    found_q;
	logic                 have_q;
	logic [IDX_W-1:0]     pend_idx_q;
	pms_pay_t             pend_pay_q;
	logic [VER_W-1:0]     hdr_version_q;
	logic [SLOT_W-1:0]    ld_slot_q;
	pms_load_t            ld_q;

	logic                 strobe_q;
	logic [SLOT_W-1:0]    out_slot_q;
	pms_pay_t             out_pay_q;
	logic [VER_W-1:0]     out_version_q;
	logic [TS_W-1:0]      out_ts_q;
	logic                 last_q;

	logic                 accept;
	logic                 in_range;
	logic                 search_end;
	logic                 tick_go;
	logic                 mod_go;
	logic                 disable_go;
	logic                 load_go;
	logic                 win_go;
	logic                 out_go;
	logic                 out_last;
	logic                 cnt_inc;
	logic                 cfg_wr;

	logic                 mod_done;
	logic [PERIOD_W-1:0]  mod_rem;
	logic [SUM_W-1:0]     load_sum;
	logic [TIME_BITS-1:0] load_due;
	pms_load_t            ld_bus;

	logic [NUM_SLOTS:0]   c_valid;
	logic [TIME_BITS-1:0] c_late [NUM_SLOTS+1];
	logic [IDX_W-1:0]     c_idx  [NUM_SLOTS+1];
	pms_pay_t             c_pay  [NUM_SLOTS+1];
	pms_cell_ctrl_t       c_ctrl [NUM_SLOTS];

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign in_range   = (32'(slot) < 32'(NUM_SLOTS));
	assign search_end = (cnt_q == CNT_W'(NUM_SLOTS));
	assign cfg_wr     = psel && penable && pwrite && pready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == CMD_TICK)) begin
					state_d = ST_SEARCH;
				end else if (accept && in_range && (period != '0)) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (mod_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_SEARCH: begin
				if (search_end) begin
					if (!c_valid[NUM_SLOTS]) begin
						state_d = ST_IDLE;
					end else if (found_q == EMIT_W'(MAX_EMIT - 1)) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The winner of a search is held back until the next search shows whether
	// another emission follows, which decides the last flag; a flush sends it as last.
	always_comb begin
		tick_go    = 1'b0;
		mod_go     = 1'b0;
		disable_go = 1'b0;
		load_go    = 1'b0;
		win_go     = 1'b0;
		out_go     = 1'b0;
		out_last   = 1'b0;
		cnt_inc    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == CMD_TICK)) begin
					tick_go = 1'b1;
				end else if (accept && in_range) begin
					mod_go     = (period != '0);
					disable_go = (period == '0);
				end
			end
			ST_DIV: begin
				load_go = mod_done;
			end
			ST_SEARCH: begin
				if (search_end) begin
					win_go   = c_valid[NUM_SLOTS];
					out_go   = have_q;
					out_last = !c_valid[NUM_SLOTS];
				end else begin
					cnt_inc = 1'b1;
				end
			end
			ST_FLUSH: begin
				out_go   = 1'b1;
				out_last = 1'b1;
			end
			default: begin
				cnt_inc = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			now_q         <= '0;
			cnt_q         <= '0;
			found_q       <= '0;
			have_q        <= 1'b0;
			strobe_q      <= 1'b0;
			hdr_version_q <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= out_go;
			if (cfg_wr) begin
				hdr_version_q <= pwdata[VER_W-1:0];
			end
			if (tick_go) begin
				now_q   <= now_q + TIME_BITS'(1);
				cnt_q   <= '0;
				found_q <= '0;
				have_q  <= 1'b0;
			end else if (win_go) begin
				cnt_q   <= '0;
				found_q <= found_q + EMIT_W'(1);
				have_q  <= 1'b1;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mod_go) begin
			ld_slot_q   <= slot;
			ld_q.source <= source_node;
			ld_q.kind   <= message_kind;
			ld_q.period <= period;
		end
		if (win_go) begin
			pend_idx_q <= c_idx[NUM_SLOTS];
			pend_pay_q <= c_pay[NUM_SLOTS];
		end
		if (out_go) begin
			out_slot_q    <= SLOT_W'(pend_idx_q);
			out_pay_q     <= pend_pay_q;
			out_version_q <= hdr_version_q;
			out_ts_q      <= TS_W'(now_q);
			last_q        <= out_last;
		end
	end

	pms_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mod_go),
		.num    (start_offset),
		.den    (period),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	assign load_sum = SUM_W'(now_q) + SUM_W'(mod_rem);
	assign load_due = load_sum[TIME_BITS-1:0];
	assign ld_bus   = ld_q;

	assign c_valid[0] = 1'b0;
	assign c_late[0]  = '0;
	assign c_idx[0]   = '0;
	assign c_pay[0]   = '0;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		always_comb begin
			c_ctrl[i].clear_emitted = tick_go;
			c_ctrl[i].emit_sel      = win_go && (c_idx[NUM_SLOTS] == IDX_W'(i));
			c_ctrl[i].load_sel      = load_go && (32'(ld_slot_q) == 32'(i));
			c_ctrl[i].disable_sel   = disable_go && (32'(slot) == 32'(i));
		end

		pms_cell #(
			.TIME_BITS (TIME_BITS),
			.IDX_W     (IDX_W),
			.CELL_IDX  (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.now       (now_q),
			.ctrl      (c_ctrl[i]),
			.load      (ld_bus),
			.load_due  (load_due),
			.in_valid  (c_valid[i]),
			.in_late   (c_late[i]),
			.in_idx    (c_idx[i]),
			.in_pay    (c_pay[i]),
			.out_valid (c_valid[i+1]),
			.out_late  (c_late[i+1]),
			.out_idx   (c_idx[i+1]),
			.out_pay   (c_pay[i+1])
		);
	end

	assign strobe        = strobe_q;
	assign out_slot      = out_slot_q;
	assign out_source    = out_pay_q.source;
	assign out_kind      = out_pay_q.kind;
	assign out_sequence  = out_pay_q.seq;
	assign out_version   = out_version_q;
	assign out_timestamp = out_ts_q;
	assign last          = last_q;

	assign prdata = (paddr == 2'b00) ? 32'(hdr_version_q) : 32'(hdr_version_q);
	assign pready = 1'b1;

endmodule

FILE: verif/tb.sv
module tb;
	import pms_pkg::*;

	localparam int SLOTS       = 64;
	localparam int STALL_LIMIT = 2000;
	localparam int LOAD_SETTLE = 40;
	localparam int END_SETTLE  = 100;

	typedef struct packed {
		logic                cmd;
		logic [SLOT_W-1:0]   slot;
		logic [SRC_W-1:0]    source;
		logic [KIND_W-1:0]   kind;
		logic [PERIOD_W-1:0] period;
		logic [PERIOD_W-1:0] offset;
	} sched_cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [SRC_W-1:0]  source;
		logic [KIND_W-1:0] kind;
		logic [SEQ_W-1:0]  seq;
		logic [VER_W-1:0]  version;
		logic [TS_W-1:0]   stamp;
		logic              last;
	} emission_t;

	// When known is set, the row's outcome is written out by hand: one emission
	// if emits is set, none otherwise. Other rows are checked against the schedule model.
	typedef struct packed {
		sched_cmd_t c;
		logic       known;
		logic       emits;
		emission_t  e;
	} dir_row_t;

	localparam emission_t NONE = '0;
	localparam int PLAN_LEN = 23;
	localparam dir_row_t PLAN [PLAN_LEN] = '{
		// A tick ignores the slot fields, so they carry all ones here.
		'{'{CMD_TICK, 6'd63, 8'hFF, 8'hFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b1, 1'b0, NONE},
		'{'{CMD_LOAD, 6'd0, 8'hFF, 8'h00, 24'd1, 24'd0}, 1'b1, 1'b0, NONE},
		'{'{CMD_TICK, 6'd0, 8'h00, 8'h00, 24'd0, 24'd0}, 1'b1, 1'b1,
			'{6'd0, 8'hFF, 8'h00, 16'd0, 16'd0, 32'd2, 1'b1}},
		'{'{CMD_LOAD, 6'd63, 8'h00, 8'hFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b1, 1'b0, NONE},
		'{'{CMD_TICK, 6'd0, 8'h00, 8'h00, 24'd0, 24'd0}, 1'b0, 1'b0, NONE},
		'{'{CMD_LOAD, 6'd0, 8'hAA, 8'h55, 24'd0, 24'd0}, 1'b1, 1'b0, NONE},
		'{'{CMD_TICK, 6'd0, 8'h00, 8'h00, 24'd0, 24'd0}, 1'b1, 1'b0, NONE},
		'{'{CMD_LOAD, 6'd5, 8'h12, 8'h34, 24'd3, 24'd7}, 1'b1, 1'b0, NONE},
		'{'{CMD_TICK, 6'd0, 8'h00, 8'h00, 24'd0, 24'd0}, 1'b1, 1'b1,
			'{6'd5, 8'h12, 8'h34, 16'd0, 16'd0, 32'd5, 1'b1}},
		'{'{CMD_TICK, 6'd0, 8'h00, 8'h00, 24'd0, 24'd0}, 1'b1, 1'b0, NONE},
		'{'{CMD_TICK, 6'd0, 8'h00, 8'h00, 24'd0, 24'd0}, 1'b1, 1'b0, NONE},
		'{'{CMD_TICK, 6'd0, 8'h00, 8'h00, 24'd0, 24'd0}, 1'b1, 1'b1,
			'{6'd5, 8'h12, 8'h34, 16'd1, 16'd0, 32'd8, 1'b1}},
		'{'{CMD_LOAD, 6'd0, 8'h80, 8'h01, 24'd2, 24'd1}, 1'b1, 1'b0, NONE},
		'{'{CMD_LOAD, 6'd32, 8'h5A, 8'hA5, 24'h800000, 24'h7FFFFF}, 1'b1, 1'b0, NONE},
		'{'{CMD_TICK, 6'd0, 8'h00, 8'h00, 24'd0, 24'd0}, 1'b1, 1'b1,
			'{6'd0, 8'h80, 8'h01, 16'd0, 16'd0, 32'd9, 1'b1}},
		'{'{CMD_TICK, 6'd0, 8'h00, 8'h00, 24'd0, 24'd0}, 1'b1, 1'b0, NONE},
		'{'{CMD_TICK, 6'd0, 8'h00, 8'h00, 24'd0, 24'd0}, 1'b0, 1'b0, NONE},
		'{'{CMD_LOAD, 6'd5, 8'h00, 8'h00, 24'd0, 24'd0}, 1'b1, 1'b0, NONE},
		'{'{CMD_LOAD, 6'd5, 8'h3C, 8'hC3, 24'd5, 24'd4}, 1'b1, 1'b0, NONE},
		'{'{CMD_TICK, 6'd0, 8'h00, 8'h00, 24'd0, 24'd0}, 1'b1, 1'b0, NONE},
		'{'{CMD_TICK, 6'd0, 8'h00, 8'h00, 24'd0, 24'd0}, 1'b1, 1'b1,
			'{6'd0, 8'h80, 8'h01, 16'd2, 16'd0, 32'd13, 1'b1}},
		'{'{CMD_TICK, 6'd0, 8'h00, 8'h00, 24'd0, 24'd0}, 1'b1, 1'b0, NONE},
		'{'{CMD_TICK, 6'd0, 8'h00, 8'h00, 24'd0, 24'd0}, 1'b0, 1'b0, NONE}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                cmd;
	logic [SLOT_W-1:0]   slot;
	logic [SRC_W-1:0]    source_node;
	logic [KIND_W-1:0]   message_kind;
	logic [PERIOD_W-1:0] period;
	logic [PERIOD_W-1:0] start_offset;
	logic                strobe;
	logic [SLOT_W-1:0]   out_slot;
	logic [SRC_W-1:0]    out_source;
	logic [KIND_W-1:0]   out_kind;
	logic [SEQ_W-1:0]    out_sequence;
	logic [VER_W-1:0]    out_version;
	logic [TS_W-1:0]     out_timestamp;
	logic                last;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [1:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	// Schedule model state
	logic                slot_on [SLOTS];
	logic [SRC_W-1:0]    slot_src [SLOTS];
	logic [KIND_W-1:0]   slot_kind [SLOTS];
	logic [PERIOD_W-1:0] slot_per [SLOTS];
	logic [TS_W-1:0]     slot_due [SLOTS];
	logic [SEQ_W-1:0]    slot_seq [SLOTS];
	logic [TS_W-1:0]     clock_us;
	logic [VER_W-1:0]    version_reg;

	emission_t pending_emissions [$];
	int        mismatches = 0;
	int        emission_no = 0;
	int        idle_cycles = 0;
	bit        steady = 1'b0;

	periodic_message_scheduler_core dut (.*);

	always #5 clk = ~clk;

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("check failed at emission %0d: %s got %0h want %0h",
			emission_no, what, got, want);
		mismatches++;
	endtask

	function automatic void advance_schedule(sched_cmd_t c, bit record);
		logic [SLOT_W-1:0] order [SLOTS];
		logic [TS_W-1:0]   lag [SLOTS];
		int                n;
		int                j;
		int                s;
		emission_t         e;
		if (c.cmd == CMD_LOAD) begin
			if (c.period == '0) begin
				slot_on[c.slot] = 1'b0;
			end else begin
				slot_on[c.slot]   = 1'b1;
				slot_src[c.slot]  = c.source;
				slot_kind[c.slot] = c.kind;
				slot_per[c.slot]  = c.period;
				slot_seq[c.slot]  = '0;
				slot_due[c.slot]  = clock_us + TS_W'(c.offset % c.period);
			end
			return;
		end
		clock_us = clock_us + TS_W'(1);
		n = 0;
		// Latest first; a strict compare keeps ties in slot order.
		for (s = 0; s < SLOTS; s++) begin
			lag[s] = clock_us - slot_due[s];
			if (slot_on[s] && !lag[s][TS_W-1]) begin
				j = n;
				while (j > 0 && lag[order[j-1]] < lag[s]) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = SLOT_W'(s);
				n++;
			end
		end
		if (n > MAX_EMIT)
			n = MAX_EMIT;
		for (j = 0; j < n; j++) begin
			e.slot    = order[j];
			e.source  = slot_src[order[j]];
			e.kind    = slot_kind[order[j]];
			e.seq     = slot_seq[order[j]];
			e.version = version_reg;
			e.stamp   = clock_us;
			e.last    = (j == n - 1);
			if (record)
				pending_emissions.push_back(e);
			slot_due[order[j]] = slot_due[order[j]] + TS_W'(slot_per[order[j]]);
			slot_seq[order[j]] = slot_seq[order[j]] + SEQ_W'(1);
		end
	endfunction

	function automatic sched_cmd_t random_cmd();
		sched_cmd_t c;
		int         pick;
		c.cmd    = ($urandom_range(99) < 45) ? CMD_TICK : CMD_LOAD;
		c.slot   = SLOT_W'($urandom);
		c.source = SRC_W'($urandom);
		c.kind   = KIND_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 8)
			c.period = '0;
		else if (pick < 20)
			c.period = PERIOD_W'($urandom);
		else
			c.period = PERIOD_W'($urandom_range(1, 12));
		c.offset = $urandom_range(1) ? PERIOD_W'($urandom) : PERIOD_W'($urandom_range(0, 15));
		return c;
	endfunction

	// Returns at the edge where the transaction is taken; start stays high.
	task automatic issue(sched_cmd_t c);
		while (!steady && $urandom_range(99) < 35) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start        <= 1'b1;
		cmd          <= c.cmd;
		slot         <= c.slot;
		source_node  <= c.source;
		message_kind <= c.kind;
		period       <= c.period;
		start_offset <= c.offset;
		do @(posedge clk); while (busy);
	endtask

	task automatic end_phase(int settle);
		start <= 1'b0;
		while (pending_emissions.size() != 0 || busy)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic check_version();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= 2'd0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {16'h0000, version_reg})
			flag_mismatch("header_version readback", prdata, {16'h0000, version_reg});
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_version(logic [VER_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 2'd0;
		pwdata  <= {16'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		version_reg = v;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		check_version();
	endtask

	task automatic random_traffic(int count);
		sched_cmd_t c;
		for (int i = 0; i < count; i++) begin
			c = random_cmd();
			issue(c);
			advance_schedule(c, 1'b1);
		end
	endtask

	always @(posedge clk) begin : emission_monitor
		emission_t want;
		if (arst_n && strobe) begin
			if (pending_emissions.size() == 0) begin
				flag_mismatch("unexpected emission from slot", 32'(out_slot), 32'h0);
			end else begin
				want = pending_emissions.pop_front();
				if (out_slot !== want.slot)
					flag_mismatch("out_slot", 32'(out_slot), 32'(want.slot));
				if (out_source !== want.source)
					flag_mismatch("out_source", 32'(out_source), 32'(want.source));
				if (out_kind !== want.kind)
					flag_mismatch("out_kind", 32'(out_kind), 32'(want.kind));
				if (out_sequence !== want.seq)
					flag_mismatch("out_sequence", 32'(out_sequence), 32'(want.seq));
				if (out_version !== want.version)
					flag_mismatch("out_version", 32'(out_version), 32'(want.version));
				if (out_timestamp !== want.stamp)
					flag_mismatch("out_timestamp", out_timestamp, want.stamp);
				if (last !== want.last)
					flag_mismatch("last", 32'(last), 32'(want.last));
			end
			emission_no++;
		end
	end

	// Any cycle with a transaction on the command or result channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		sched_cmd_t c;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		cmd          <= CMD_LOAD;
		slot         <= '0;
		source_node  <= '0;
		message_kind <= '0;
		period       <= '0;
		start_offset <= '0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= 2'd0;
		pwdata       <= '0;
		clock_us     = '0;
		version_reg  = '0;
		for (int s = 0; s < SLOTS; s++) begin
			slot_on[s]   = 1'b0;
			slot_src[s]  = '0;
			slot_kind[s] = '0;
			slot_per[s]  = '0;
			slot_due[s]  = '0;
			slot_seq[s]  = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_version();

		for (int r = 0; r < PLAN_LEN; r++) begin
			issue(PLAN[r].c);
			advance_schedule(PLAN[r].c, !PLAN[r].known);
			if (PLAN[r].known && PLAN[r].emits)
				pending_emissions.push_back(PLAN[r].e);
		end
		end_phase(LOAD_SETTLE);

		set_version(16'hFFFF);
		random_traffic(110);
		end_phase(LOAD_SETTLE);

		set_version(VER_W'($urandom));
		random_traffic(70);
		end_phase(LOAD_SETTLE);

		set_version(16'h8001);
		random_traffic(70);
		end_phase(LOAD_SETTLE);

		// Every slot due on the same tick: the longest burst, sent back to back.
		set_version(16'h0000);
		steady = 1'b1;
		for (int s = 0; s < SLOTS; s++) begin
			c.cmd    = CMD_LOAD;
			c.slot   = SLOT_W'(s);
			c.source = SRC_W'($urandom);
			c.kind   = KIND_W'($urandom);
			c.period = PERIOD_W'(1);
			c.offset = PERIOD_W'($urandom);
			issue(c);
			advance_schedule(c, 1'b1);
		end
		c = '0;
		c.cmd = CMD_TICK;
		repeat (3) begin
			issue(c);
			advance_schedule(c, 1'b1);
		end
		steady = 1'b0;
		end_phase(END_SETTLE);

		if (pending_emissions.size() != 0)
			flag_mismatch("emissions never seen", pending_emissions.size(), 32'h0);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
